/* rtl/ffca_pkg.sv */
// Shared constants, codes and control types of the first-fit allocator.
package ffca_pkg;

    localparam int FREE_SLOTS    = 16;
    localparam int LIVE_SLOTS    = 64;
    localparam int HEADER_BYTES  = 32;
    localparam int POINTER_BYTES = 8;
    localparam int GRANULE       = 16;
    localparam int MIN_ALIGN     = 4;
    localparam int MIN_BLOCK     = HEADER_BYTES + GRANULE;

    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int LIW = $clog2(LIVE_SLOTS);

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_BAD     = 3'd1,
        STAT_NOFIT   = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_NEED, S_FIT, S_SLOT, S_ALLOC,
        S_LRD, S_LCMP, S_POS, S_FREE, S_SUM, S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    check;
        logic    need;
        logic    fit_step;
        logic    slot;
        logic    alloc;
        logic    lrd;
        logic    lcmp;
        logic    pos_step;
        logic    free_apply;
        logic    sum_init;
        logic    sum_step;
        logic    res_set;
        status_t res_code;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad;
        logic null_addr;
        logic fit_end;
        logic fit_hit;
        logic slot_none;
        logic live_hit;
        logic scan_last;
        logic pos_stop;
        logic ins_full;
        logic sum_end;
    } stat_t;

endpackage

/* rtl/ffca_req_if.sv */
// Request channel: valid/ready handshake with allocate/free payload.
interface ffca_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] req_size;
    logic [31:0] req_align;
    logic [31:0] release_addr;

    modport source (output valid, op, req_size, req_align, release_addr, input ready);
    modport sink   (input valid, op, req_size, req_align, release_addr, output ready);
endinterface

/* rtl/ffca_rsp_if.sv */
// Result channel: valid/ready handshake with status and heap figures.
interface ffca_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_addr;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;

    modport source (output valid, status, result_addr, used_bytes, free_bytes, input ready);
    modport sink   (input valid, status, result_addr, used_bytes, free_bytes, output ready);
endinterface

/* rtl/ffca_dp.sv */
// Allocator datapath: extent table, live-block memory, sizing and scan arithmetic.
module ffca_dp import ffca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_op,
    input  logic [31:0] in_size,
    input  logic [31:0] in_align,
    input  logic [31:0] in_raddr,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [2:0]  status,
    output logic [31:0] result_addr,
    output logic [31:0] used_bytes,
    output logic [31:0] free_bytes
);

    logic [31:0]      base_reg, size_reg, used_reg;
    logic [31:0]      fs_reg [FREE_SLOTS];
    logic [31:0]      fl_reg [FREE_SLOTS];
    logic [FCW-1:0]   fcnt_reg;
    logic [LIVE_SLOTS-1:0] lvalid_reg;
    logic [95:0]      live_mem [LIVE_SLOTS];

    logic             op_reg;
    logic [31:0]      rsize_reg, ralign_reg, raddr_reg;
    logic [34:0]      pay_reg;
    logic [35:0]      need_reg;
    logic [FCW-1:0]   idx_reg;
    logic [LIW-1:0]   slot_reg, scan_reg;
    logic [31:0]      ua_reg;
    logic [95:0]      rd_reg;
    logic             prev_ok_reg;
    logic [32:0]      prev_end_reg;
    logic [31:0]      prev_sum_reg, acc_reg, addr_reg;
    status_t          status_reg;

    logic [31:0]      al, cur_s, cur_l, blen, rd_ua, rd_bs, rd_bl;
    logic             big, in_range, split, mp, mn, ins_full, slot_none, live_hit;
    logic [34:0]      pay_next;
    logic [35:0]      need_next;
    logic [33:0]      ua_base, ua_al;
    logic [FIW-1:0]   ix, pm;
    logic [LIW-1:0]   slot_enc;
    logic [31:0]      new_base, new_size;
    logic [32:0]      lim, sz;
    logic             reinit_one;

    assign rd_ua = rd_reg[95:64];
    assign rd_bs = rd_reg[63:32];
    assign rd_bl = rd_reg[31:0];

    assign al  = (ralign_reg < 32'(MIN_ALIGN)) ? 32'(MIN_ALIGN) : ralign_reg;
    assign big = al > 32'(GRANULE);
    assign pay_next = big ? {3'b0, rsize_reg} + {3'b0, al} + 35'(POINTER_BYTES + HEADER_BYTES)
                          : {3'b0, rsize_reg};
    assign need_next = (({1'b0, pay_reg} + 36'(GRANULE - 1)) & ~36'(GRANULE - 1))
                       + 36'(HEADER_BYTES);

    assign ix       = idx_reg[FIW-1:0];
    assign pm       = ix - 1'b1;
    assign cur_s    = fs_reg[ix];
    assign cur_l    = fl_reg[ix];
    assign in_range = idx_reg < fcnt_reg;

    assign ua_base = {2'b0, cur_s} + 34'(HEADER_BYTES);
    assign ua_al   = ({2'b0, cur_s} + 34'(2 * HEADER_BYTES + POINTER_BYTES - 1) + {2'b0, al})
                     & ~({2'b0, al} - 34'd1);

    assign split = {4'b0, cur_l} >= need_reg + 36'(MIN_BLOCK);
    assign blen  = split ? need_reg[31:0] : cur_l;

    assign live_hit = lvalid_reg[scan_reg] && (rd_ua == raddr_reg);
    assign mp       = prev_ok_reg && (prev_end_reg == {1'b0, rd_bs});
    assign mn       = in_range && (({1'b0, rd_bs} + {1'b0, rd_bl}) == {1'b0, cur_s});
    assign ins_full = !mp && !mn && (fcnt_reg == FCW'(FREE_SLOTS));

    always_comb
    begin
        slot_none = 1'b1;
        slot_enc  = '0;
        for (int k = LIVE_SLOTS - 1; k >= 0; k--)
        begin
            if (!lvalid_reg[k])
            begin
                slot_none = 1'b0;
                slot_enc  = LIW'(k);
            end
        end
    end

    // re-initialisation on any register write
    assign new_base   = (cfg_index == CFG_HEAP_BASE) ? {cfg_wdata[31:4], 4'b0} : base_reg;
    assign new_size   = (cfg_index == CFG_HEAP_SIZE) ? cfg_wdata : size_reg;
    assign lim        = 33'h1_0000_0000 - {1'b0, new_base};
    assign sz         = ({1'b0, new_size} > lim) ? lim : {1'b0, new_size};
    assign reinit_one = sz >= 33'(MIN_BLOCK);

    always_comb
    begin
        stat.is_free   = op_reg == OP_FREE;
        stat.bad       = (rsize_reg == 32'd0) || (ralign_reg == 32'd0) ||
                         ((al & (al - 32'd1)) != 32'd0);
        stat.null_addr = raddr_reg == 32'd0;
        stat.fit_end   = !in_range;
        stat.fit_hit   = in_range && ({4'b0, cur_l} >= need_reg);
        stat.slot_none = slot_none;
        stat.live_hit  = live_hit;
        stat.scan_last = scan_reg == LIW'(LIVE_SLOTS - 1);
        stat.pos_stop  = !(in_range && (cur_s < rd_bs));
        stat.ins_full  = ins_full;
        stat.sum_end   = !in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            size_reg   <= '0;
            used_reg   <= '0;
            fcnt_reg   <= '0;
            lvalid_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg   <= new_base;
            size_reg   <= new_size;
            used_reg   <= '0;
            fcnt_reg   <= reinit_one ? FCW'(1) : '0;
            lvalid_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            lvalid_reg[slot_reg] <= 1'b1;
            used_reg             <= used_reg + blen;
            if (!split)
                fcnt_reg <= fcnt_reg - 1'b1;
        end
        else if (cmd.free_apply && !ins_full)
        begin
            lvalid_reg[scan_reg] <= 1'b0;
            used_reg <= (used_reg >= rd_bl) ? used_reg - rd_bl : 32'd0;
            if (mp && mn)
                fcnt_reg <= fcnt_reg - 1'b1;
            else if (!mp && !mn)
                fcnt_reg <= fcnt_reg + 1'b1;
        end
    end

    // extent table
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            fs_reg[0] <= new_base;
            fl_reg[0] <= sz[31:0];
        end
        else if (cmd.alloc)
        begin
            if (split)
            begin
                fs_reg[ix] <= cur_s + need_reg[31:0];
                fl_reg[ix] <= cur_l - need_reg[31:0];
            end
            else
            begin
                for (int k = 0; k < FREE_SLOTS - 1; k++)
                begin
                    if (k >= int'(ix))
                    begin
                        fs_reg[k] <= fs_reg[k + 1];
                        fl_reg[k] <= fl_reg[k + 1];
                    end
                end
            end
        end
        else if (cmd.free_apply && !ins_full)
        begin
            if (mp && mn)
            begin
                for (int k = 0; k < FREE_SLOTS - 1; k++)
                begin
                    if (k >= int'(ix))
                    begin
                        fs_reg[k] <= fs_reg[k + 1];
                        fl_reg[k] <= fl_reg[k + 1];
                    end
                end
                fl_reg[pm] <= prev_sum_reg + cur_l;
            end
            else if (mp)
            begin
                fl_reg[pm] <= prev_sum_reg;
            end
            else if (mn)
            begin
                fs_reg[ix] <= rd_bs;
                fl_reg[ix] <= cur_l + rd_bl;
            end
            else
            begin
                for (int k = FREE_SLOTS - 1; k > 0; k--)
                begin
                    if (k > int'(ix))
                    begin
                        fs_reg[k] <= fs_reg[k - 1];
                        fl_reg[k] <= fl_reg[k - 1];
                    end
                end
                fs_reg[ix] <= rd_bs;
                fl_reg[ix] <= rd_bl;
            end
        end
    end

    // live-block memory: user address, block start, block length
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
            live_mem[slot_reg] <= {ua_reg, cur_s, blen};
        if (cmd.lrd)
            rd_reg <= live_mem[scan_reg];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            rsize_reg  <= in_size;
            ralign_reg <= in_align;
            raddr_reg  <= in_raddr;
            addr_reg   <= '0;
            scan_reg   <= '0;
        end
        if (cmd.check)
            pay_reg <= pay_next;
        if (cmd.slot)
        begin
            slot_reg <= slot_enc;
            ua_reg   <= big ? ua_al[31:0] : ua_base[31:0];
        end
        if (cmd.alloc)
            addr_reg <= ua_reg;
        if (cmd.res_set)
            status_reg <= cmd.res_code;
        if (cmd.lcmp && !live_hit)
            scan_reg <= scan_reg + 1'b1;

        if (cmd.sum_init)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.need)
        begin
            need_reg <= need_next;
            idx_reg  <= '0;
        end
        else if (cmd.fit_step && in_range && !stat.fit_hit)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.lcmp)
        begin
            idx_reg     <= '0;
            prev_ok_reg <= 1'b0;
        end
        else if (cmd.pos_step && !stat.pos_stop)
        begin
            prev_ok_reg  <= 1'b1;
            prev_end_reg <= {1'b0, cur_s} + {1'b0, cur_l};
            prev_sum_reg <= cur_l + rd_bl;
            idx_reg      <= idx_reg + 1'b1;
        end
        else if (cmd.sum_step && in_range)
        begin
            acc_reg <= acc_reg + ((cur_l > 32'(HEADER_BYTES)) ? cur_l - 32'(HEADER_BYTES) : 32'd0);
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign status      = status_reg;
    assign result_addr = addr_reg;
    assign used_bytes  = used_reg;
    assign free_bytes  = acc_reg;

endmodule

/* rtl/ffca_ctrl.sv */
// Allocator controller: sequences checks, scans, table updates and the result beat.
module ffca_ctrl import ffca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = STAT_OK;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.is_free)
                begin
                    if (stat.null_addr)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_IGNORED;
                        cmd.sum_init = 1'b1;
                        state_next   = S_SUM;
                    end
                    else
                        state_next = S_LRD;
                end
                else if (stat.bad)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_BAD;
                    cmd.sum_init = 1'b1;
                    state_next   = S_SUM;
                end
                else
                    state_next = S_NEED;
            end
            S_NEED:
            begin
                cmd.need   = 1'b1;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                cmd.fit_step = 1'b1;
                if (stat.fit_hit)
                    state_next = S_SLOT;
                else if (stat.fit_end)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_NOFIT;
                    cmd.sum_init = 1'b1;
                    state_next   = S_SUM;
                end
            end
            S_SLOT:
            begin
                cmd.slot = 1'b1;
                if (stat.slot_none)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_FULL;
                    cmd.sum_init = 1'b1;
                    state_next   = S_SUM;
                end
                else
                    state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc    = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = STAT_OK;
                cmd.sum_init = 1'b1;
                state_next   = S_SUM;
            end
            S_LRD:
            begin
                cmd.lrd    = 1'b1;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                cmd.lcmp = 1'b1;
                if (stat.live_hit)
                    state_next = S_POS;
                else if (stat.scan_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_IGNORED;
                    cmd.sum_init = 1'b1;
                    state_next   = S_SUM;
                end
                else
                    state_next = S_LRD;
            end
            S_POS:
            begin
                cmd.pos_step = 1'b1;
                if (stat.pos_stop)
                    state_next = S_FREE;
            end
            S_FREE:
            begin
                cmd.free_apply = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_code   = stat.ins_full ? STAT_FULL : STAT_OK;
                cmd.sum_init   = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/first_fit_coalescing_allocator_top.sv */
// First-fit heap allocator with coalescing of free extents: top level.
//
// Requests arrive as beats on in_ch (op 0 allocate, op 1 free); every request
// gives exactly one result beat on out_ch with status, granted address, bytes
// in live blocks and free payload bytes. Items are handled one at a time:
// in_ch.ready is high only while the block is idle.
// An allocate runs its checks, a first-fit scan (one extent a cycle) and a
// free-bytes sum (one extent a cycle); a free has a live-table lookup (a
// read and a compare per entry, one memory read port) and an insertion scan.
// The result stays on out_ch until taken; while the receiver stalls no new
// request is accepted.
// Register writes (cfg_we, cfg_index, cfg_wdata) re-initialise the heap at
// once; the user must make them only while idle, as the block itself does
// not enforce it. Reset clears both tables (no clearing pass), base and
// size to zero.
module first_fit_coalescing_allocator_top import ffca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ffca_req_if.sink    in_ch,
    ffca_rsp_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    ffca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffca_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_op       (in_ch.op),
        .in_size     (in_ch.req_size),
        .in_align    (in_ch.req_align),
        .in_raddr    (in_ch.release_addr),
        .cmd         (cmd),
        .stat        (stat),
        .status      (out_ch.status),
        .result_addr (out_ch.result_addr),
        .used_bytes  (out_ch.used_bytes),
        .free_bytes  (out_ch.free_bytes)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("request taken while a result beat is pending");

    a_not_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
        else $error("result beat in the cycle after acceptance");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != STAT_OK) |-> out_ch.result_addr == 32'd0)
        else $error("address reported on a failed request");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.alloc, cmd.free_apply, cmd.lrd, cmd.sum_step}))
        else $error("conflicting datapath commands");

endmodule

/* tb/first_fit_coalescing_allocator_top_test.sv */
// Testbench for the first-fit coalescing allocator: directed table, random phases, predictor.
`timescale 1ns / 100ps

module first_fit_coalescing_allocator_top_test;
    import ffca_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] addr;
    } heap_req_t;

    typedef struct {
        status_t     st;
        logic [31:0] addr;
        logic [31:0] used;
        logic [31:0] free;
    } heap_rsp_t;

    // grant_ref >= 0 frees the address of that earlier grant; typed rows carry their answer
    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] addr;
        int          grant_ref;
        bit          typed;
        status_t     st;
        logic [31:0] raddr;
        logic [31:0] used;
        logic [31:0] free;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_HEAP_BASE;
    logic [31:0] cfg_wdata = '0;

    ffca_req_if req_ch ();
    ffca_rsp_if rsp_ch ();

    first_fit_coalescing_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [31:0] hp_base, hp_size;
    logic [31:0] ext_start [FREE_SLOTS];
    logic [31:0] ext_len [FREE_SLOTS];
    int          ext_count;
    logic [31:0] blk_user [LIVE_SLOTS];
    logic [31:0] blk_start [LIVE_SLOTS];
    logic [31:0] blk_len [LIVE_SLOTS];
    bit          blk_live [LIVE_SLOTS];
    logic [31:0] used_sum;

    heap_rsp_t   pending_rsp [$];
    heap_rsp_t   typed_rsp [$];
    bit          typed_flag [$];
    logic [31:0] grants [$];
    int          errors = 0;
    int          n_req = 0;
    int          n_rsp = 0;
    int          st_seen [5];
    int          hold_left = 0;
    int          quiet = 0;

    function automatic logic [63:0] gran16(logic [63:0] x);
        return (x + 64'd15) & ~64'd15;
    endfunction

    function automatic void heap_reinit();
        logic [63:0] lim;
        logic [63:0] sz;
        lim = 64'h1_0000_0000 - {32'b0, hp_base};
        sz = {32'b0, hp_size};
        if (sz > lim)
            sz = lim;
        ext_count = 0;
        used_sum = '0;
        foreach (blk_live[s])
            blk_live[s] = 1'b0;
        if (sz >= MIN_BLOCK)
        begin
            ext_start[0] = hp_base;
            ext_len[0] = sz[31:0];
            ext_count = 1;
        end
    endfunction

    function automatic void ext_remove(int i);
        for (int k = i; k + 1 < ext_count; k++)
        begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_count--;
    endfunction

    function automatic bit ext_merge_in(logic [31:0] st, logic [31:0] len);
        int  i;
        bit  mp, mn;
        i = 0;
        while (i < ext_count && ext_start[i] < st)
            i++;
        mp = i > 0 && ({32'b0, ext_start[i - 1]} + ext_len[i - 1]) == {32'b0, st};
        mn = i < ext_count && ({32'b0, st} + len) == {32'b0, ext_start[i]};
        if (mp && mn)
        begin
            ext_len[i - 1] = ext_len[i - 1] + len + ext_len[i];
            ext_remove(i);
        end
        else if (mp)
            ext_len[i - 1] = ext_len[i - 1] + len;
        else if (mn)
        begin
            ext_start[i] = st;
            ext_len[i] = ext_len[i] + len;
        end
        else
        begin
            if (ext_count >= FREE_SLOTS)
                return 1'b0;
            for (int k = ext_count; k > i; k--)
            begin
                ext_start[k] = ext_start[k - 1];
                ext_len[k] = ext_len[k - 1];
            end
            ext_start[i] = st;
            ext_len[i] = len;
            ext_count++;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] free_payload();
        logic [63:0] n;
        n = '0;
        for (int i = 0; i < ext_count; i++)
            if (ext_len[i] > HEADER_BYTES)
                n += {32'b0, ext_len[i]} - HEADER_BYTES;
        return n[31:0];
    endfunction

    function automatic status_t heap_alloc(logic [31:0] size, logic [31:0] align,
                                           output logic [31:0] ua_out);
        logic [63:0] al, payload, need, ua;
        int          i, slot;
        ua_out = '0;
        if (size == 0 || align == 0)
            return STAT_BAD;
        al = {32'b0, align};
        if (al < MIN_ALIGN)
            al = MIN_ALIGN;
        if ((al & (al - 1)) != 0)
            return STAT_BAD;
        payload = al <= GRANULE ? {32'b0, size}
                                : {32'b0, size} + al + POINTER_BYTES + HEADER_BYTES;
        need = gran16(HEADER_BYTES + gran16(payload));
        for (i = 0; i < ext_count; i++)
            if ({32'b0, ext_len[i]} >= need)
                break;
        if (i >= ext_count)
            return STAT_NOFIT;
        for (slot = 0; slot < LIVE_SLOTS; slot++)
            if (!blk_live[slot])
                break;
        if (slot >= LIVE_SLOTS)
            return STAT_FULL;
        blk_start[slot] = ext_start[i];
        if ({32'b0, ext_len[i]} >= need + MIN_BLOCK)
        begin
            blk_len[slot] = need[31:0];
            ext_start[i] = ext_start[i] + need[31:0];
            ext_len[i] = ext_len[i] - need[31:0];
        end
        else
        begin
            blk_len[slot] = ext_len[i];
            ext_remove(i);
        end
        ua = {32'b0, blk_start[slot]} + HEADER_BYTES;
        if (al > GRANULE)
            ua = (ua + POINTER_BYTES + HEADER_BYTES + (al - 1)) & ~(al - 1);
        blk_user[slot] = ua[31:0];
        blk_live[slot] = 1'b1;
        used_sum = used_sum + blk_len[slot];
        ua_out = ua[31:0];
        return STAT_OK;
    endfunction

    function automatic status_t heap_release(logic [31:0] a);
        int s;
        if (a == 0)
            return STAT_IGNORED;
        for (s = 0; s < LIVE_SLOTS; s++)
            if (blk_live[s] && blk_user[s] == a)
                break;
        if (s >= LIVE_SLOTS)
            return STAT_IGNORED;
        if (!ext_merge_in(blk_start[s], blk_len[s]))
            return STAT_FULL;
        blk_live[s] = 1'b0;
        used_sum = used_sum >= blk_len[s] ? used_sum - blk_len[s] : '0;
        return STAT_OK;
    endfunction

    function automatic heap_rsp_t heap_step(heap_req_t r);
        heap_rsp_t o;
        o.addr = '0;
        if (r.op == OP_FREE)
            o.st = heap_release(r.addr);
        else
            o.st = heap_alloc(r.size, r.align, o.addr);
        o.used = used_sum;
        o.free = free_payload();
        return o;
    endfunction

    function automatic void heap_write_reg(logic idx, logic [31:0] v);
        if (idx == CFG_HEAP_BASE)
            hp_base = v & 32'hFFFF_FFF0;
        else
            hp_size = v;
        heap_reinit();
    endfunction

    // accepted beats: predict on requests, compare on results
    always @(posedge clk)
    begin
        heap_req_t r;
        heap_rsp_t p, e;
        if (rst_n)
        begin
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_rsp++;
                if (pending_rsp.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = pending_rsp.pop_front();
                    if (rsp_ch.status !== e.st)
                    begin
                        $error("status exp %0d got %0d", e.st, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.result_addr !== e.addr)
                    begin
                        $error("result_addr exp %h got %h", e.addr, rsp_ch.result_addr);
                        errors++;
                    end
                    if (rsp_ch.used_bytes !== e.used)
                    begin
                        $error("used_bytes exp %h got %h", e.used, rsp_ch.used_bytes);
                        errors++;
                    end
                    if (rsp_ch.free_bytes !== e.free)
                    begin
                        $error("free_bytes exp %h got %h", e.free, rsp_ch.free_bytes);
                        errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                n_req++;
                r.op = req_ch.op;
                r.size = req_ch.req_size;
                r.align = req_ch.req_align;
                r.addr = req_ch.release_addr;
                p = heap_step(r);
                st_seen[p.st]++;
                if (r.op == OP_ALLOC && p.st == STAT_OK)
                    grants.push_back(p.addr);
                if (typed_flag.size() != 0 && typed_flag.pop_front())
                    pending_rsp.push_back(typed_rsp.pop_front());
                else
                    pending_rsp.push_back(p);
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_req(heap_req_t r, bit typed, heap_rsp_t t);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        typed_flag.push_back(typed);
        if (typed)
            typed_rsp.push_back(t);
        req_ch.valid <= 1'b1;
        req_ch.op <= r.op;
        req_ch.req_size <= r.size;
        req_ch.req_align <= r.align;
        req_ch.release_addr <= r.addr;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        heap_write_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        grants.delete();
    endtask

    function automatic logic [31:0] live_pick(bit even_only);
        int idx [$];
        foreach (blk_live[s])
            if (blk_live[s] && (!even_only || s % 2 == 0))
                idx.push_back(s);
        if (idx.size() == 0)
            return $urandom;
        return blk_user[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    function automatic heap_req_t rand_req(int alloc_pct);
        heap_req_t r;
        int        k;
        r.op = OP_ALLOC;
        r.size = $urandom_range(1, 256);
        r.align = 32'd1 << $urandom_range(0, 6);
        r.addr = $urandom;
        k = $urandom_range(0, 99);
        if (k < alloc_pct)
        begin
            if ($urandom_range(0, 9) == 0)
                r.size = $urandom_range(1, 4096);
            if ($urandom_range(0, 19) == 0)
                r.size = $urandom;
            if ($urandom_range(0, 9) == 0)
                r.align = 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 29) == 0)
                r.align = $urandom_range(0, 1) ? $urandom : 32'd0;
            if ($urandom_range(0, 49) == 0)
                r.size = 32'd0;
        end
        else
        begin
            r.op = OP_FREE;
            r.size = $urandom;
            r.align = $urandom;
            k = $urandom_range(0, 19);
            if (k < 16)
                r.addr = live_pick(1'b0);
            else if (k < 17)
                r.addr = 32'd0;
            else if (k < 18)
                r.addr = live_pick(1'b0) + 32'd1;
        end
        return r;
    endfunction

    // fill with small blocks, then free live blocks from even-numbered slots to fragment the free list
    task automatic comb_burst(int n);
        heap_req_t r;
        heap_rsp_t none;
        none = '{STAT_OK, '0, '0, '0};
        r.align = 32'd4;
        r.addr = '0;
        repeat (n)
        begin
            r.op = OP_ALLOC;
            r.size = $urandom_range(1, 64);
            send_req(r, 1'b0, none);
        end
        repeat (n / 2)
        begin
            r.op = OP_FREE;
            r.size = $urandom;
            r.align = $urandom;
            r.addr = live_pick(1'b1);
            send_req(r, 1'b0, none);
        end
    endtask

    localparam int DIR_N = 20;
    dir_row_t dir_tab [DIR_N] = '{
        '{OP_ALLOC, 32'd16, 32'd16, 32'd0, -1, 1'b1, STAT_NOFIT, 32'd0, 32'd0, 32'd0},
        '{OP_ALLOC, 32'd0, 32'd16, 32'd0, -1, 1'b1, STAT_BAD, 32'd0, 32'd0, 32'd0},
        '{OP_ALLOC, 32'd16, 32'd0, 32'd0, -1, 1'b1, STAT_BAD, 32'd0, 32'd0, 32'd0},
        '{OP_ALLOC, 32'd16, 32'd6, 32'd0, -1, 1'b1, STAT_BAD, 32'd0, 32'd0, 32'd0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, -1, 1'b1, STAT_IGNORED, 32'd0, 32'd0, 32'd0},
        '{OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 1'b1, STAT_IGNORED,
          32'd0, 32'd0, 32'd0},
        '{OP_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, -1, 1'b1, STAT_NOFIT,
          32'd0, 32'd0, 32'd0},
        // heap configured from here on
        '{OP_ALLOC, 32'd1, 32'd1, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'd1, 32'd16, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'd100, 32'd64, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'd200, 32'd32, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'd4096, 32'h8000_0000, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'hFFFF_FFFF, 32'd4, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, 1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, 0, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, 3, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, 2, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_FREE, 32'd0, 32'd0, 32'd0, 2, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'd16, 32'h800, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0},
        '{OP_ALLOC, 32'hFFF0, 32'd2, 32'd0, -1, 1'b0, STAT_OK, 0, 0, 0}
    };

    localparam int PHASES = 7;
    logic [31:0] ph_base [PHASES] = '{32'h0000_1000, 32'h0, 32'h1234_567F, 32'hFFFF_FFF0,
                                      32'h4000_0000, 32'hFFFF_0000, 32'h0000_2000};
    logic [31:0] ph_size [PHASES] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h800, 32'hFFFF_FFFF,
                                      32'h0010_0000, 32'hFFFF_FFFF, 32'h0};

    initial
    begin
        heap_req_t r;
        heap_rsp_t t;
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.req_size = '0;
        req_ch.req_align = '0;
        req_ch.release_addr = '0;
        hp_base = '0;
        hp_size = '0;
        heap_reinit();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (i == 7)
            begin
                write_reg(CFG_HEAP_BASE, 32'h0000_1000);
                write_reg(CFG_HEAP_SIZE, 32'h0001_0000);
            end
            r.op = dir_tab[i].op;
            r.size = dir_tab[i].size;
            r.align = dir_tab[i].align;
            r.addr = dir_tab[i].addr;
            if (dir_tab[i].grant_ref >= 0 && dir_tab[i].grant_ref < grants.size())
                r.addr = grants[dir_tab[i].grant_ref];
            t = '{dir_tab[i].st, dir_tab[i].raddr, dir_tab[i].used, dir_tab[i].free};
            send_req(r, dir_tab[i].typed, t);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(CFG_HEAP_BASE, ph_base[ph]);
            write_reg(CFG_HEAP_SIZE, ph_size[ph]);
            if (ph == 1)
                hold_left = 400;
            for (int n = 0; n < 90; n++)
            begin
                if (n == 10)
                    comb_burst($urandom_range(0, 1) ? 70 : 40);
                send_req(rand_req(ph % 2 ? 45 : 65), 1'b0, t);
            end
        end

        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests, %0d results over %0d heap settings", n_req, n_rsp, PHASES + 2);
        $display("ok %0d, bad %0d, no fit %0d, ignored %0d, table full %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
